FILE: sv/kmp_pkg.sv
// Package for the KMP substring finder: sizes, command codes, FSM states
// and the structs passed between the controller and the table memories.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

    // Pattern capacity and the text offset range
    localparam int     MAX_PATTERN = 64;
    localparam longint MAX_TEXT    = 64'd1048576;

    localparam int PIDX_W  = $clog2(MAX_PATTERN);
    localparam int PLEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int TPOS_W  = $clog2(MAX_TEXT);
    localparam int START_W = 20;

    localparam logic [TPOS_W-1:0] POS_LAST = TPOS_W'(MAX_TEXT - 1);

    // Input word commands
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2
    } cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } kmp_state_t;

    // Request to the pattern and failure memories
    typedef struct packed {
        logic [PIDX_W-1:0] rd_addr;
        logic              wr_en;
        logic [PIDX_W-1:0] wr_addr;
        logic [7:0]        wr_byte;
        logic [PIDX_W-1:0] wr_fail;
    } kmp_mem_req_t;

    // Registered read data, returned in the cycle after the address
    typedef struct packed {
        logic [7:0]        pat_byte;
        logic [PIDX_W-1:0] fail;
    } kmp_mem_rsp_t;

    // One result word
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] match_start;
        logic               overflow;
    } kmp_result_t;

endpackage

`default_nettype wire

FILE: sv/kmp_tables.sv
// Pattern store and failure table: two synchronous memories sharing one
// read address and one write port, read data registered.
// Depends on kmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmp_tables (
    input  wire logic                  clk,
    input  wire kmp_pkg::kmp_mem_req_t mem_req,
    output kmp_pkg::kmp_mem_rsp_t      mem_rsp
);
    import kmp_pkg::*;

    logic [7:0]        pat_mem  [MAX_PATTERN];
    logic [PIDX_W-1:0] fail_mem [MAX_PATTERN];

    // Both tables are written together when a pattern entry is completed.
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            pat_mem[mem_req.wr_addr]  <= mem_req.wr_byte;
            fail_mem[mem_req.wr_addr] <= mem_req.wr_fail;
        end
    end

    // Registered read of the entry addressed this cycle.
    always_ff @(posedge clk)
    begin
        mem_rsp.pat_byte <= pat_mem[mem_req.rd_addr];
        mem_rsp.fail     <= fail_mem[mem_req.rd_addr];
    end

endmodule

`default_nettype wire

FILE: sv/kmp_ctrl.sv
// Controller of the KMP finder: takes input words, walks the failure chain
// through the table memories and keeps pattern length, match and text state.
// Depends on kmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            cmd,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_text,
    output kmp_pkg::kmp_mem_req_t      mem_req,
    input  wire kmp_pkg::kmp_mem_rsp_t mem_rsp,
    output logic                       res_valid,
    output kmp_pkg::kmp_result_t       res,
    input  wire logic                  res_free
);
    import kmp_pkg::*;

    kmp_state_t        state_reg, state_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [PLEN_W-1:0] midx_reg, midx_next;
    logic [TPOS_W-1:0] pos_reg, pos_next;
    logic              latched_reg, latched_next;
    logic [TPOS_W-1:0] lstart_reg, lstart_next;
    logic              ovf_reg, ovf_next;
    logic [7:0]        prev_byte_reg, prev_byte_next;
    logic [PIDX_W-1:0] prev_fail_reg, prev_fail_next;
    logic [PIDX_W-1:0] k_reg, k_next;
    logic [7:0]        cmp_byte_reg, cmp_byte_next;
    logic [7:0]        new_byte_reg, new_byte_next;
    logic              is_append_reg, is_append_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              mismatch;
    logic              step_more;
    logic [PLEN_W-1:0] k_new;
    logic [PIDX_W-1:0] k_start;
    logic [TPOS_W-1:0] pos_adv;
    logic [TPOS_W:0]   pos_inc;
    logic [TPOS_W:0]   plen_ext;
    logic [TPOS_W-1:0] start_calc;

    assign accept = in_valid && in_ready;

    // Walk step: compare against the entry read last cycle.
    assign mismatch  = (cmp_byte_reg != mem_rsp.pat_byte);
    assign step_more = (k_reg != '0) && mismatch;
    assign k_new     = mismatch ? '0 : (PLEN_W'(k_reg) + PLEN_W'(1));

    // A stale match index past the pattern end restarts at zero.
    assign k_start = (midx_reg >= plen_reg) ? '0 : midx_reg[PIDX_W-1:0];

    // Saturating text offset and the start offset of a match ending here.
    assign pos_adv    = (pos_reg == POS_LAST) ? pos_reg : (pos_reg + TPOS_W'(1));
    assign pos_inc    = {1'b0, pos_reg} + (TPOS_W + 1)'(1);
    assign plen_ext   = (TPOS_W + 1)'(plen_reg);
    assign start_calc = (pos_inc >= plen_ext) ? TPOS_W'(pos_inc - plen_ext) : '0;

    // Next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        plen_next      = plen_reg;
        midx_next      = midx_reg;
        pos_next       = pos_reg;
        latched_next   = latched_reg;
        lstart_next    = lstart_reg;
        ovf_next       = ovf_reg;
        prev_byte_next = prev_byte_reg;
        prev_fail_next = prev_fail_reg;
        k_next         = k_reg;
        cmp_byte_next  = cmp_byte_reg;
        new_byte_next  = new_byte_reg;
        is_append_next = is_append_reg;
        last_next      = last_reg;

        in_ready        = (state_reg == ST_IDLE);
        mem_req.rd_addr = k_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = plen_reg[PIDX_W-1:0];
        mem_req.wr_byte = new_byte_reg;
        mem_req.wr_fail = '0;

        res_valid         = 1'b0;
        res.found         = (plen_reg == '0) || latched_reg;
        res.match_start   = ((plen_reg != '0) && latched_reg) ? START_W'(lstart_reg) : '0;
        res.overflow      = ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            plen_next    = '0;
                            ovf_next     = 1'b0;
                            midx_next    = '0;
                            pos_next     = '0;
                            latched_next = 1'b0;
                            lstart_next  = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (plen_reg == PLEN_W'(MAX_PATTERN))
                            begin
                                ovf_next = 1'b1;
                            end
                            else if (plen_reg < PLEN_W'(2))
                            begin
                                // The first two failure entries are zero.
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_byte = data_byte;
                                plen_next       = plen_reg + PLEN_W'(1);
                                prev_byte_next  = data_byte;
                                prev_fail_next  = '0;
                            end
                            else
                            begin
                                // Walk from the previous entry's failure link.
                                mem_req.rd_addr = prev_fail_reg;
                                k_next          = prev_fail_reg;
                                cmp_byte_next   = prev_byte_reg;
                                new_byte_next   = data_byte;
                                is_append_next  = 1'b1;
                                state_next      = ST_WALK;
                            end
                        end
                        CMD_TEXT:
                        begin
                            if (!latched_reg && (plen_reg != '0))
                            begin
                                mem_req.rd_addr = k_start;
                                k_next          = k_start;
                                cmp_byte_next   = data_byte;
                                is_append_next  = 1'b0;
                                last_next       = end_of_text;
                                state_next      = ST_WALK;
                            end
                            else
                            begin
                                pos_next = pos_adv;
                                if (end_of_text)
                                begin
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // Follow the failure link straight from the read data.
                mem_req.rd_addr = mem_rsp.fail;
                if (step_more)
                begin
                    k_next = mem_rsp.fail;
                end
                else if (is_append_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_fail = k_new[PIDX_W-1:0];
                    plen_next       = plen_reg + PLEN_W'(1);
                    prev_byte_next  = new_byte_reg;
                    prev_fail_next  = k_new[PIDX_W-1:0];
                    state_next      = ST_IDLE;
                end
                else
                begin
                    midx_next = k_new;
                    if (k_new == plen_reg)
                    begin
                        latched_next = 1'b1;
                        lstart_next  = start_calc;
                    end
                    pos_next   = pos_adv;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                // Hand the result over, then restart the text state.
                if (res_free)
                begin
                    res_valid    = 1'b1;
                    midx_next    = '0;
                    pos_next     = '0;
                    latched_next = 1'b0;
                    lstart_next  = '0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plen_reg      <= '0;
            midx_reg      <= '0;
            pos_reg       <= '0;
            latched_reg   <= 1'b0;
            lstart_reg    <= '0;
            ovf_reg       <= 1'b0;
            prev_byte_reg <= '0;
            prev_fail_reg <= '0;
            k_reg         <= '0;
            cmp_byte_reg  <= '0;
            new_byte_reg  <= '0;
            is_append_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plen_reg      <= plen_next;
            midx_reg      <= midx_next;
            pos_reg       <= pos_next;
            latched_reg   <= latched_next;
            lstart_reg    <= lstart_next;
            ovf_reg       <= ovf_next;
            prev_byte_reg <= prev_byte_next;
            prev_fail_reg <= prev_fail_next;
            k_reg         <= k_next;
            cmp_byte_reg  <= cmp_byte_next;
            new_byte_reg  <= new_byte_next;
            is_append_reg <= is_append_next;
            last_reg      <= last_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/kmp_substring_finder_core.sv
// Clear, a dropped append, the first two appends and a text byte after a match or
// with an empty pattern finish in the idle state; a later append or an unmatched text
// byte walks the failure chain (at most pattern length links) through the single table
// read port. A final text byte passes the emit state; input is taken only when idle.
// Reset: rst_n asynchronous, active low; clears pattern length, flags and text state.
// Depends on kmp_pkg, kmp_ctrl and kmp_tables.
`timescale 1ns / 1ps
`default_nettype none

module kmp_substring_finder_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 cmd,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       end_of_text,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            found,
    output logic [kmp_pkg::START_W-1:0]     match_start,
    output logic                            pattern_overflow
);
    import kmp_pkg::*;

    kmp_mem_req_t mem_req;
    kmp_mem_rsp_t mem_rsp;
    logic         res_valid;
    kmp_result_t  res;
    logic         res_free;

    logic         out_valid_reg, out_valid_next;
    kmp_result_t  out_res_reg, out_res_next;

    kmp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .mem_req     (mem_req),
        .mem_rsp     (mem_rsp),
        .res_valid   (res_valid),
        .res         (res),
        .res_free    (res_free)
    );

    kmp_tables u_tables (
        .clk     (clk),
        .mem_req (mem_req),
        .mem_rsp (mem_rsp)
    );

    // Output word register; the controller keeps taking input while it waits.
    assign res_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign found            = out_res_reg.found;
    assign match_start      = out_res_reg.match_start;
    assign pattern_overflow = out_res_reg.overflow;

endmodule

`default_nettype wire

FILE: sv/kmp_checker.sv
// Port-level checks for the KMP substring finder, bound to the top level.
// Depends on kmp_pkg and kmp_substring_finder_core.
`timescale 1ns / 1ps
`default_nettype none

module kmp_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic [1:0]                 cmd,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       end_of_text,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic                       found,
    input  wire logic [kmp_pkg::START_W-1:0] match_start,
    input  wire logic                       pattern_overflow
);
    import kmp_pkg::*;

    // No output word is shown while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // A stalled output word holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found)
            && $stable(match_start) && $stable(pattern_overflow))
        else $error("output word changed while stalled");

    // A miss always reports offset zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_start == '0)
        else $error("nonzero match_start without a match");

    // Once a result is handed over the block is ready for the next word.
    a_ready_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("not ready after result was emitted");

    // Right after a clear, a one-byte text reports a match at offset zero.
    // The word passes the emit state and then the output register.
    a_empty_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd == CMD_CLEAR) ##1
        (in_valid && in_ready && cmd == CMD_TEXT && end_of_text && !out_valid)
        |=> ##1 (out_valid && found && match_start == '0))
        else $error("empty pattern did not report a match at zero");

endmodule

bind kmp_substring_finder_core kmp_checker u_kmp_checker (.*);

`default_nettype wire
